>>> rtl/core/mflg_pkg.sv
package mflg_pkg;

    // Sizing of the node and edge stores.
    localparam int MAX_NODES = 256;
    localparam int MAX_EDGES = 1024;

    // Derived widths.
    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int LVL_W  = CNT_W;
    localparam int PAIR_W = $clog2(MAX_EDGES + 1);
    localparam int SLOT_W = $clog2(2 * MAX_EDGES);
    localparam int SCAN_W = SLOT_W + 1;
    localparam int CAP_W  = 32;
    localparam int FLOW_W = 31;
    localparam int TOT_W  = 48;
    localparam int CFG_W  = 9;
    localparam int CIDX_W = 2;

    localparam logic [LVL_W-1:0]  LEVEL_NONE = '1;
    localparam logic [FLOW_W-1:0] FLOW_INF   = '1;

    // Action codes.
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_RUN   = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_SOURCE     = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_SINK       = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
        logic [FLOW_W-1:0] capacity;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [TOT_W-1:0] max_flow;
    } t_out_item;

    typedef struct packed {
        logic [NODE_W-1:0] tail;
        logic [NODE_W-1:0] head;
    } t_edge;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [LVL_W-1:0]  level;
    } t_qent;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [SCAN_W-1:0] cursor;
        logic [SLOT_W-1:0] taken;
        logic [FLOW_W-1:0] limit;
    } t_frame;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_ADD_REV, S_LV_CLR, S_LV_SRC, S_BQ_RD, S_BQ_LD,
        S_BE_RD, S_BE_CHK, S_BE_LV, S_VS_CLR, S_VS_SRC, S_DE_RD, S_DP_LD,
        S_DE_CHK, S_DE_VL, S_AU_RS, S_AU_RT, S_AU_W1, S_AU_W2, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CLEAR, OP_ADD_FULL, OP_ADD_BAD, OP_ADD_FWD,
        OP_ADD_REV, OP_RUN_BAD, OP_RES_OK, OP_RUN_INIT, OP_LV_CLR, OP_LV_SRC,
        OP_BQ_POP, OP_BQ_LOAD, OP_E_RD, OP_E_NEXT, OP_VL_RD, OP_BE_MARK,
        OP_BFS_END, OP_VS_CLR, OP_VS_SRC, OP_POP, OP_FR_LOAD, OP_PUSH,
        OP_AU_RS, OP_AU_RT, OP_AU_W1, OP_AU_W2, OP_AU_END, OP_PHASE_END,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic [1:0] action;
        logic       full;
        logic       node_bad;
        logic       run_bad;
        logic       src_eq_snk;
        logic       lv_last;
        logic       q_empty;
        logic       e_end;
        logic       edge_hit;
        logic       push_ok;
        logic       at_sink;
        logic       dfs_bottom;
        logic       aug_end;
        logic       out_free;
    } t_dp_stat;

endpackage

>>> rtl/core/mflg_ram.sv
module mflg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/mflg_ctrl.sv
module mflg_ctrl import mflg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output t_dp_op   o_op,
    output logic     o_in_stall
);

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_stat.action == ACT_ADD) begin
                    if (i_stat.full || i_stat.node_bad) n_state = S_DONE;
                    else n_state = S_ADD_REV;
                end else if (i_stat.action == ACT_RUN) begin
                    if (i_stat.run_bad || i_stat.src_eq_snk) n_state = S_DONE;
                    else n_state = S_LV_CLR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_ADD_REV: n_state = S_DONE;
            S_LV_CLR: begin
                if (i_stat.lv_last) n_state = S_LV_SRC;
            end
            S_LV_SRC: n_state = S_BQ_RD;
            S_BQ_RD: begin
                n_state = i_stat.q_empty ? S_VS_CLR : S_BQ_LD;
            end
            S_BQ_LD: n_state = S_BE_RD;
            S_BE_RD: begin
                n_state = i_stat.e_end ? S_BQ_RD : S_BE_CHK;
            end
            S_BE_CHK: begin
                n_state = i_stat.edge_hit ? S_BE_LV : S_BE_RD;
            end
            S_BE_LV: n_state = S_BE_RD;
            S_VS_CLR: begin
                if (i_stat.lv_last) n_state = S_VS_SRC;
            end
            S_VS_SRC: n_state = S_DE_RD;
            S_DE_RD: begin
                if (i_stat.e_end) n_state = i_stat.dfs_bottom ? S_DONE : S_DP_LD;
                else n_state = S_DE_CHK;
            end
            S_DP_LD: n_state = S_DE_RD;
            S_DE_CHK: begin
                n_state = i_stat.edge_hit ? S_DE_VL : S_DE_RD;
            end
            S_DE_VL: begin
                if (i_stat.push_ok && i_stat.at_sink) n_state = S_AU_RS;
                else n_state = S_DE_RD;
            end
            S_AU_RS: begin
                n_state = i_stat.aug_end ? S_LV_CLR : S_AU_RT;
            end
            S_AU_RT: n_state = S_AU_W1;
            S_AU_W1: n_state = S_AU_W2;
            S_AU_W2: n_state = S_AU_RS;
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_op = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) o_op = OP_LOAD;
            end
            S_DECODE: begin
                if (i_stat.action == ACT_CLEAR) begin
                    o_op = OP_CLEAR;
                end else if (i_stat.action == ACT_ADD) begin
                    if (i_stat.full) o_op = OP_ADD_FULL;
                    else if (i_stat.node_bad) o_op = OP_ADD_BAD;
                    else o_op = OP_ADD_FWD;
                end else if (i_stat.action == ACT_RUN) begin
                    if (i_stat.run_bad) o_op = OP_RUN_BAD;
                    else if (i_stat.src_eq_snk) o_op = OP_RES_OK;
                    else o_op = OP_RUN_INIT;
                end else begin
                    o_op = OP_RES_OK;
                end
            end
            S_ADD_REV: o_op = OP_ADD_REV;
            S_LV_CLR:  o_op = OP_LV_CLR;
            S_LV_SRC:  o_op = OP_LV_SRC;
            S_BQ_RD:   o_op = i_stat.q_empty ? OP_BFS_END : OP_BQ_POP;
            S_BQ_LD:   o_op = OP_BQ_LOAD;
            S_BE_RD:   o_op = i_stat.e_end ? OP_NONE : OP_E_RD;
            S_BE_CHK:  o_op = i_stat.edge_hit ? OP_VL_RD : OP_E_NEXT;
            S_BE_LV:   o_op = OP_BE_MARK;
            S_VS_CLR:  o_op = OP_VS_CLR;
            S_VS_SRC:  o_op = OP_VS_SRC;
            S_DE_RD: begin
                if (i_stat.e_end) o_op = i_stat.dfs_bottom ? OP_PHASE_END : OP_POP;
                else o_op = OP_E_RD;
            end
            S_DP_LD:   o_op = OP_FR_LOAD;
            S_DE_CHK:  o_op = i_stat.edge_hit ? OP_VL_RD : OP_E_NEXT;
            S_DE_VL:   o_op = i_stat.push_ok ? OP_PUSH : OP_E_NEXT;
            S_AU_RS:   o_op = i_stat.aug_end ? OP_AU_END : OP_AU_RS;
            S_AU_RT:   o_op = OP_AU_RT;
            S_AU_W1:   o_op = OP_AU_W1;
            S_AU_W2:   o_op = OP_AU_W2;
            S_DONE: begin
                if (i_stat.out_free) o_op = OP_EMIT;
            end
            default: o_op = OP_NONE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

>>> rtl/core/mflg_dpath.sv
module mflg_dpath import mflg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_wr_data,
    input  t_in_item          i_in_data,
    input  logic              i_out_stall,
    input  t_dp_op            i_op,
    output t_dp_stat          o_stat,
    output logic              o_out_valid,
    output t_out_item         o_out_data
);

    logic [CFG_W-1:0]  r_node_count;
    logic [NODE_W-1:0] r_src, r_snk;
    t_in_item          r_item;
    logic [PAIR_W-1:0] r_pairs, n_pairs;
    logic [NODE_W-1:0] r_u, n_u;
    logic [LVL_W-1:0]  r_lev_u, n_lev_u;
    logic [FLOW_W-1:0] r_lim, n_lim;
    logic [SCAN_W-1:0] r_e, n_e;
    logic [CNT_W-1:0]  r_i, n_i, r_qh, n_qh, r_qt, n_qt, r_depth, n_depth, r_k, n_k;
    logic [SLOT_W-1:0] r_t, n_t;
    logic [TOT_W-1:0]  r_total, n_total;
    t_out_item         r_res, n_res, r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic [CNT_W-1:0]  n_eff;
    logic [SCAN_W-1:0] slots;
    logic [SLOT_W-1:0] pair_slot, t_alt;
    logic [FLOW_W-1:0] new_lim;
    logic              lv_none;

    // RAM ports.
    logic              edge_we, edge_re, cap_we, cap_re;
    logic [SLOT_W-1:0] edge_waddr, cap_waddr, cap_raddr;
    t_edge             edge_wdata, edge_q;
    logic [CAP_W-1:0]  cap_wdata, cap_q;
    logic              lvl_we, lvl_re, vis_we, vis_wdata, vis_q;
    logic [NODE_W-1:0] lvl_waddr, vis_waddr, nd_raddr;
    logic [LVL_W-1:0]  lvl_wdata, lvl_q;
    logic              q_we, q_re, stk_we, stk_re;
    logic [NODE_W-1:0] q_waddr, q_raddr, stk_waddr, stk_raddr;
    t_qent             q_wdata, q_q;
    t_frame            stk_wdata, stk_q;

    // Effective node count and edge slot bounds.
    assign n_eff     = (r_node_count > CFG_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                          : CNT_W'(r_node_count);
    assign slots     = {r_pairs, 1'b0};
    assign pair_slot = SLOT_W'({r_pairs, 1'b0});
    assign t_alt     = {r_t[SLOT_W-1:1], ~r_t[0]};
    assign new_lim   = (cap_q < {1'b0, r_lim}) ? cap_q[FLOW_W-1:0] : r_lim;
    assign lv_none   = (lvl_q == LEVEL_NONE);

    // Status toward the controller.
    always_comb begin
        o_stat.action     = r_item.action;
        o_stat.full       = (r_pairs >= PAIR_W'(MAX_EDGES));
        o_stat.node_bad   = ({1'b0, r_item.from_node} >= n_eff) ||
                            ({1'b0, r_item.to_node} >= n_eff);
        o_stat.run_bad    = ({1'b0, r_src} >= n_eff) || ({1'b0, r_snk} >= n_eff);
        o_stat.src_eq_snk = (r_src == r_snk);
        o_stat.lv_last    = (r_i == n_eff - CNT_W'(1));
        o_stat.q_empty    = (r_qh == r_qt);
        o_stat.e_end      = (r_e == slots);
        o_stat.edge_hit   = (edge_q.tail == r_u) && ({1'b0, edge_q.head} < n_eff) &&
                            (cap_q != '0);
        o_stat.push_ok    = !vis_q && (lvl_q == r_depth) &&
                            (r_depth < CNT_W'(MAX_NODES));
        o_stat.at_sink    = (edge_q.head == r_snk);
        o_stat.dfs_bottom = (r_depth == CNT_W'(1));
        o_stat.aug_end    = (r_k == r_depth - CNT_W'(1));
        o_stat.out_free   = !r_out_valid || !i_out_stall;
    end

    // Edge endpoint store.
    always_comb begin
        edge_we    = (i_op == OP_ADD_FWD) || (i_op == OP_ADD_REV);
        edge_waddr = (i_op == OP_ADD_REV) ? (pair_slot | SLOT_W'(1)) : pair_slot;
        edge_wdata = (i_op == OP_ADD_REV) ? t_edge'({r_item.to_node, r_item.from_node})
                                          : t_edge'({r_item.from_node, r_item.to_node});
        edge_re    = (i_op == OP_E_RD);
    end

    // Residual capacity store.
    always_comb begin
        cap_we    = 1'b0;
        cap_waddr = pair_slot;
        cap_wdata = {1'b0, r_item.capacity};
        cap_re    = 1'b0;
        cap_raddr = r_e[SLOT_W-1:0];
        case (i_op)
            OP_ADD_FWD: cap_we = 1'b1;
            OP_ADD_REV: begin
                cap_we    = 1'b1;
                cap_waddr = pair_slot | SLOT_W'(1);
                cap_wdata = '0;
            end
            OP_E_RD: cap_re = 1'b1;
            OP_AU_RT: begin
                cap_re    = 1'b1;
                cap_raddr = stk_q.taken;
            end
            OP_AU_W1: begin
                cap_we    = 1'b1;
                cap_waddr = r_t;
                cap_wdata = cap_q - {1'b0, r_lim};
                cap_re    = 1'b1;
                cap_raddr = t_alt;
            end
            OP_AU_W2: begin
                cap_we    = 1'b1;
                cap_waddr = t_alt;
                cap_wdata = cap_q + {1'b0, r_lim};
            end
            default: ;
        endcase
    end

    // Level, visited, queue and path stack ports.
    always_comb begin
        nd_raddr  = edge_q.head;
        lvl_re    = (i_op == OP_VL_RD);
        lvl_we    = 1'b0;
        lvl_waddr = r_i[NODE_W-1:0];
        lvl_wdata = LEVEL_NONE;
        vis_we    = 1'b0;
        vis_waddr = r_i[NODE_W-1:0];
        vis_wdata = 1'b0;
        q_we      = 1'b0;
        q_waddr   = r_qt[NODE_W-1:0];
        q_wdata   = t_qent'({edge_q.head, r_lev_u + LVL_W'(1)});
        q_re      = (i_op == OP_BQ_POP);
        q_raddr   = r_qh[NODE_W-1:0];
        stk_we    = (i_op == OP_PUSH);
        stk_waddr = NODE_W'(r_depth - CNT_W'(1));
        stk_wdata = t_frame'({r_u, r_e + SCAN_W'(1), r_e[SLOT_W-1:0], r_lim});
        stk_re    = (i_op == OP_POP) || (i_op == OP_AU_RS);
        stk_raddr = (i_op == OP_POP) ? NODE_W'(r_depth - CNT_W'(2))
                                     : r_k[NODE_W-1:0];
        case (i_op)
            OP_LV_CLR: lvl_we = 1'b1;
            OP_LV_SRC: begin
                lvl_we    = 1'b1;
                lvl_waddr = r_src;
                lvl_wdata = '0;
                q_we      = 1'b1;
                q_waddr   = '0;
                q_wdata   = t_qent'({r_src, LVL_W'(0)});
            end
            OP_BE_MARK: begin
                lvl_we    = lv_none;
                lvl_waddr = edge_q.head;
                lvl_wdata = r_lev_u + LVL_W'(1);
                q_we      = lv_none && (r_qt < CNT_W'(MAX_NODES));
            end
            OP_VS_CLR: vis_we = 1'b1;
            OP_VS_SRC: begin
                vis_we    = 1'b1;
                vis_waddr = r_src;
                vis_wdata = 1'b1;
            end
            OP_PUSH: begin
                vis_we    = 1'b1;
                vis_waddr = edge_q.head;
                vis_wdata = 1'b1;
            end
            default: ;
        endcase
    end

    // Register next values.
    always_comb begin
        n_pairs     = r_pairs;
        n_u         = r_u;
        n_lev_u     = r_lev_u;
        n_lim       = r_lim;
        n_e         = r_e;
        n_i         = r_i;
        n_qh        = r_qh;
        n_qt        = r_qt;
        n_depth     = r_depth;
        n_k         = r_k;
        n_t         = r_t;
        n_total     = r_total;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        case (i_op)
            OP_CLEAR: begin
                n_pairs = '0;
                n_res   = '{status: ST_OK, max_flow: '0};
            end
            OP_ADD_FULL: n_res = '{status: ST_FULL, max_flow: '0};
            OP_ADD_BAD:  n_res = '{status: ST_RANGE, max_flow: '0};
            OP_ADD_REV: begin
                n_pairs = r_pairs + PAIR_W'(1);
                n_res   = '{status: ST_OK, max_flow: '0};
            end
            OP_RUN_BAD: n_res = '{status: ST_RANGE, max_flow: '0};
            OP_RES_OK:  n_res = '{status: ST_OK, max_flow: '0};
            OP_RUN_INIT: begin
                n_total = '0;
                n_i     = '0;
            end
            OP_LV_CLR: n_i = r_i + CNT_W'(1);
            OP_LV_SRC: begin
                n_qh = '0;
                n_qt = CNT_W'(1);
            end
            OP_BQ_POP: n_qh = r_qh + CNT_W'(1);
            OP_BQ_LOAD: begin
                n_u     = q_q.node;
                n_lev_u = q_q.level;
                n_e     = '0;
            end
            OP_E_NEXT: n_e = r_e + SCAN_W'(1);
            OP_BE_MARK: begin
                if (lv_none && (r_qt < CNT_W'(MAX_NODES))) n_qt = r_qt + CNT_W'(1);
                n_e = r_e + SCAN_W'(1);
            end
            OP_BFS_END: n_i = '0;
            OP_VS_CLR:  n_i = r_i + CNT_W'(1);
            OP_VS_SRC: begin
                n_u     = r_src;
                n_e     = '0;
                n_lim   = FLOW_INF;
                n_depth = CNT_W'(1);
            end
            OP_POP: n_depth = r_depth - CNT_W'(1);
            OP_FR_LOAD: begin
                n_u   = stk_q.node;
                n_e   = stk_q.cursor;
                n_lim = stk_q.limit;
            end
            OP_PUSH: begin
                n_u     = edge_q.head;
                n_lim   = new_lim;
                n_e     = '0;
                n_depth = r_depth + CNT_W'(1);
                n_k     = '0;
            end
            OP_AU_RT: n_t = stk_q.taken;
            OP_AU_W2: n_k = r_k + CNT_W'(1);
            OP_AU_END: begin
                n_total = r_total + TOT_W'(r_lim);
                n_i     = '0;
            end
            OP_PHASE_END: n_res = '{status: ST_OK, max_flow: r_total};
            OP_EMIT: begin
                n_out       = r_res;
                n_out_valid = 1'b1;
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CFG_W'(256);
            r_src        <= NODE_W'(1);
            r_snk        <= NODE_W'(255);
            r_pairs      <= '0;
            r_qh         <= '0;
            r_qt         <= '0;
            r_depth      <= '0;
            r_k          <= '0;
            r_i          <= '0;
            r_e          <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_NODE_COUNT: r_node_count <= i_cfg_wr_data;
                    CFG_SOURCE:     r_src <= i_cfg_wr_data[NODE_W-1:0];
                    CFG_SINK:       r_snk <= i_cfg_wr_data[NODE_W-1:0];
                    default: ;
                endcase
            end
            r_pairs     <= n_pairs;
            r_qh        <= n_qh;
            r_qt        <= n_qt;
            r_depth     <= n_depth;
            r_k         <= n_k;
            r_i         <= n_i;
            r_e         <= n_e;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_op == OP_LOAD) r_item <= i_in_data;
        r_u     <= n_u;
        r_lev_u <= n_lev_u;
        r_lim   <= n_lim;
        r_t     <= n_t;
        r_total <= n_total;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    mflg_ram #(.WIDTH($bits(t_edge)), .DEPTH(2 * MAX_EDGES)) u_edge_ram (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(edge_waddr), .i_wdata(edge_wdata),
        .i_re(edge_re), .i_raddr(r_e[SLOT_W-1:0]), .o_rdata(edge_q)
    );

    mflg_ram #(.WIDTH(CAP_W), .DEPTH(2 * MAX_EDGES)) u_cap_ram (
        .i_clk(i_clk), .i_we(cap_we), .i_waddr(cap_waddr), .i_wdata(cap_wdata),
        .i_re(cap_re), .i_raddr(cap_raddr), .o_rdata(cap_q)
    );

    mflg_ram #(.WIDTH(LVL_W), .DEPTH(MAX_NODES)) u_level_ram (
        .i_clk(i_clk), .i_we(lvl_we), .i_waddr(lvl_waddr), .i_wdata(lvl_wdata),
        .i_re(lvl_re), .i_raddr(nd_raddr), .o_rdata(lvl_q)
    );

    mflg_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_visit_ram (
        .i_clk(i_clk), .i_we(vis_we), .i_waddr(vis_waddr), .i_wdata(vis_wdata),
        .i_re(lvl_re), .i_raddr(nd_raddr), .o_rdata(vis_q)
    );

    mflg_ram #(.WIDTH($bits(t_qent)), .DEPTH(MAX_NODES)) u_queue_ram (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_re(q_re), .i_raddr(q_raddr), .o_rdata(q_q)
    );

    mflg_ram #(.WIDTH($bits(t_frame)), .DEPTH(MAX_NODES)) u_stack_ram (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_re(stk_re), .i_raddr(stk_raddr), .o_rdata(stk_q)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The queue head never passes the tail.
    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qh <= r_qt) else $error("queue head passed tail");

    // The path stack stays within its store.
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= CNT_W'(MAX_NODES)) else $error("path stack overflow");

    // The edge store never holds more pairs than it has room for.
    a_pairs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pairs <= PAIR_W'(MAX_EDGES)) else $error("edge store overflow");

    // A push always deepens the path by one.
    a_push_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_PUSH) |=> (r_depth == $past(r_depth) + CNT_W'(1)))
        else $error("push did not deepen path");

endmodule

>>> rtl/core/max_flow_level_graph_engine_unit.sv
// One request at a time: o_in_stall stays high from acceptance until the result is
// emitted, and the result is held while i_out_stall is high. A run clears the node
// levels, builds them breadth-first from the source, clears the visited marks, then
// searches depth-first toward the sink and augments each edge of a found path, until no
// path is left; the edge and capacity stores each have a single read port.
// Reset clears the edge count and restores node_count 256, source 1 and sink 255.
module max_flow_level_graph_engine_unit import mflg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data
);

    t_dp_op   op;
    t_dp_stat stat;

    // Sequencer.
    mflg_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .i_stat(stat), .o_op(op), .o_in_stall(o_in_stall)
    );

    // Stores, counters and result register.
    mflg_dpath u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index), .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_data(i_in_data), .i_out_stall(i_out_stall), .i_op(op),
        .o_stat(stat), .o_out_valid(o_out_valid), .o_out_data(o_out_data)
    );

endmodule
